### sv/smrsd_pkg.sv
// Shared constants and helpers of the rotate string decryptor.
// Depends on nothing; the top level and the testbench import it.
package smrsd_pkg;

  localparam logic [63:0] SEED_RESET   = 64'hB4A5_7B0F_6DED_ABED;
  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

  // Rotate a byte right by 0..7 positions.
  function automatic logic [7:0] rot_right8(input logic [7:0] b, input logic [2:0] r);
    logic [15:0] dbl;
    dbl = {b, b} >> r;
    return dbl[7:0];
  endfunction

endpackage

### sv/smrsd_ifs.sv
// Valid/ready channel interfaces of the rotate string decryptor: input bytes,
// result bytes and the key seed write channel. No package dependency.
interface smrsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_start;
  modport source (output valid, in_byte, string_start, input ready);
  modport sink (input valid, in_byte, string_start, output ready);
endinterface

interface smrsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_string;
  logic       was_encrypted;
  modport source (output valid, out_byte, end_of_string, was_encrypted, input ready);
  modport sink (input valid, out_byte, end_of_string, was_encrypted, output ready);
endinterface

interface smrsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_seed;
  modport source (output valid, key_seed, input ready);
  modport sink (input valid, key_seed, output ready);
endinterface

### sv/splitmix_rotate_string_decrypt.sv
// Rotate string decryptor. Marker, pass-through and end beats are handled in the idle state;
// an encrypted byte is accepted, then runs two mix rounds on the shared 32x32 multiplier,
// and the input is not ready again until its result is written to the output register.
// Results wait in an output register; the input stalls while a result is held.
// Reset (rst_ni low, asynchronous) closes any string, clears the output and
// loads key seed and generator state with the seed reset value.
module splitmix_rotate_string_decrypt (
  input  logic   clk_i,
  input  logic   rst_ni,
  smrsd_in_if.sink    in_i,
  smrsd_out_if.source out_o,
  smrsd_cfg_if.sink   cfg_i
);
  import smrsd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_MUL  = 2'b10
  } state_e;

  state_e      state_q, state_d;
  logic [63:0] key_seed_q, key_seed_d;
  logic [63:0] gen_q, gen_d;
  logic        enc_q, enc_d;
  logic        active_q, active_d;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        phase_q, phase_d;
  logic [7:0]  byte_q, byte_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_end_q, out_end_d;
  logic        out_enc_q, out_enc_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] mul_k;
  logic [63:0] gen_next;
  logic [63:0] z_full;
  logic [63:0] key_word;
  logic        in_fire;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire     = in_i.valid && in_i.ready;

  assign mul_k    = phase_q ? MIX_MUL_B : MIX_MUL_A;
  assign gen_next = gen_q + GOLDEN_GAMMA;
  assign z_full   = acc_q + {mul_p[31:0], 32'd0};
  assign key_word = z_full ^ (z_full >> 31);

  // Issue low*low, low*high, high*low; the high*high term falls off the top.
  always_comb begin
    case (cnt_q)
      2'd1:    begin mul_a = x_q[31:0];  mul_b = mul_k[63:32]; end
      2'd2:    begin mul_a = x_q[63:32]; mul_b = mul_k[31:0];  end
      default: begin mul_a = x_q[31:0];  mul_b = mul_k[31:0];  end
    endcase
  end

  smrsd_mul32 u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  always_comb begin
    state_d     = state_q;
    key_seed_d  = key_seed_q;
    gen_d       = gen_q;
    enc_d       = enc_q;
    active_d    = active_q;
    x_d         = x_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    byte_d      = byte_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    out_enc_d   = out_enc_q;

    if (cfg_i.valid) begin
      key_seed_d = cfg_i.key_seed;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.string_start) begin
            gen_d    = key_seed_q;
            enc_d    = (in_i.in_byte != 8'd0);
            active_d = 1'b1;
          end else if (active_q) begin
            if (in_i.in_byte == 8'd0) begin
              out_valid_d = 1'b1;
              out_byte_d  = 8'd0;
              out_end_d   = 1'b1;
              out_enc_d   = enc_q;
              active_d    = 1'b0;
            end else if (!enc_q) begin
              out_valid_d = 1'b1;
              out_byte_d  = in_i.in_byte;
              out_end_d   = 1'b0;
              out_enc_d   = 1'b0;
            end else begin
              // advance the generator and start the first mix round
              gen_d   = gen_next;
              x_d     = gen_next ^ (gen_next >> 30);
              byte_d  = in_i.in_byte;
              cnt_d   = 2'd0;
              phase_d = 1'b0;
              state_d = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        cnt_d = cnt_q + 2'd1;
        case (cnt_q)
          2'd1:    acc_d = mul_p;
          2'd2:    acc_d = z_full;
          2'd3: begin
            if (!phase_q) begin
              x_d     = z_full ^ (z_full >> 27);
              phase_d = 1'b1;
            end else begin
              out_valid_d = 1'b1;
              out_byte_d  = rot_right8(byte_q, key_word[2:0]);
              out_end_d   = 1'b0;
              out_enc_d   = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          default: acc_d = acc_q;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_seed_q  <= SEED_RESET;
      gen_q       <= SEED_RESET;
      enc_q       <= 1'b0;
      active_q    <= 1'b0;
      cnt_q       <= 2'd0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_seed_q  <= key_seed_d;
      gen_q       <= gen_d;
      enc_q       <= enc_d;
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    acc_q      <= acc_d;
    byte_q     <= byte_d;
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
    out_enc_q  <= out_enc_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.end_of_string = out_end_q;
  assign out_o.was_encrypted = out_enc_q;

endmodule

### sv/smrsd_mul32.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Used for the partial products of the 64-bit mix multiplies; no package use.
module smrsd_mul32 (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;
  logic [63:0] p_d;

  assign p_d = {32'd0, a_i} * {32'd0, b_i};

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

### sim/splitmix_rotate_string_decrypt_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the rotate string decryptor: directed table, then
// random string traffic checked against a keystream predictor.
// Depends on smrsd_pkg, the channel interfaces and the top level of the block.
module splitmix_rotate_string_decrypt_tb;
  import smrsd_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_ITEMS  = 600;
  localparam int IDLE_GUARD    = 12;    // covers an encrypted beat in progress
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_AT       = 150;   // result index where the receiver backs off
  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 2000;
  localparam int DIRECTED_ROWS = 25;

  typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_GIVEN} check_e;
  typedef enum logic {ROW_BEAT, ROW_SEED} row_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_string;
    logic       was_encrypted;
  } string_beat_t;

  typedef struct {
    row_e         kind;
    logic [7:0]   data;
    logic         start;
    check_e       chk;
    string_beat_t want;
    logic [63:0]  seed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  smrsd_in_if  in_bus ();
  smrsd_out_if out_bus ();
  smrsd_cfg_if cfg_bus ();

  splitmix_rotate_string_decrypt i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state
  logic [63:0] model_seed;
  logic [63:0] model_gen;
  logic        model_enc;
  logic        model_open;

  string_beat_t pending_beats[$];
  stim_row_t    rows [0:DIRECTED_ROWS-1];
  int           error_count  = 0;
  int           sent_items   = 0;
  int           random_items = 0;
  int           stall_cycles = 0;

  function automatic int draw_gap(input int n);
    if ((n / 48) % 4 == 3) return 0;
    return $urandom_range(0, 4);
  endfunction

  // Advance the predicted decryptor by one input byte; 1 when a result is due.
  function automatic bit decrypt_step(input logic [7:0] data, input logic start,
                                      output string_beat_t res);
    logic [63:0] z;
    logic [2:0]  r;
    logic [7:0]  v;
    res = '0;
    if (start) begin
      model_gen  = model_seed;
      model_enc  = (data != 8'h00);
      model_open = 1'b1;
      return 1'b0;
    end
    if (!model_open) return 1'b0;
    if (data == 8'h00) begin
      res = {8'h00, 1'b1, model_enc};
      model_open = 1'b0;
      return 1'b1;
    end
    v = data;
    if (model_enc) begin
      model_gen = model_gen + GOLDEN_GAMMA;
      z = model_gen;
      z = (z ^ (z >> 30)) * MIX_MUL_A;
      z = (z ^ (z >> 27)) * MIX_MUL_B;
      z = z ^ (z >> 31);
      r = z[2:0];
      v = (data >> r) | (data << (4'd8 - r));
    end
    res = {v, 1'b0, model_enc};
    return 1'b1;
  endfunction

  function automatic stim_row_t beat_row(input logic [7:0] data, input logic start,
                                         input check_e chk, input string_beat_t want);
    stim_row_t row;
    row = '{ROW_BEAT, data, start, chk, want, 64'h0};
    return row;
  endfunction

  function automatic stim_row_t seed_row(input logic [63:0] seed);
    stim_row_t row;
    row = '{ROW_SEED, 8'h00, 1'b0, CHK_SILENT, '0, seed};
    return row;
  endfunction

  task automatic report_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic offer_byte(input logic [7:0] data, input logic start,
                            input check_e chk, input string_beat_t want);
    int           gap;
    bit           has;
    bit           counted;
    string_beat_t res;
    gap = draw_gap(sent_items);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.in_byte      <= data;
    in_bus.string_start <= start;
    in_bus.valid        <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    counted = start || model_open;
    has = decrypt_step(data, start, res);
    case (chk)
      CHK_MODEL: if (has) pending_beats = {pending_beats, res};
      CHK_GIVEN: pending_beats = {pending_beats, want};
      default: ;
    endcase
    sent_items++;
    if (counted) random_items++;
  endtask

  // Drain the block, then write the seed.
  task automatic load_seed(input logic [63:0] seed);
    in_bus.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
    cfg_bus.key_seed <= seed;
    cfg_bus.valid    <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    model_seed = seed;
  endtask

  task automatic send_string_bytes(input int len, input bit terminate);
    for (int i = 0; i < len; i++) offer_byte(8'($urandom_range(1, 255)), 1'b0, CHK_MODEL, '0);
    if (terminate) offer_byte(8'h00, 1'b0, CHK_MODEL, '0);
  endtask

  task automatic send_string(input bit terminate);
    logic [7:0] marker;
    marker = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    offer_byte(marker, 1'b1, CHK_MODEL, '0);
    send_string_bytes($urandom_range(0, 12), terminate);
  endtask

  // Result checker
  always @(posedge clk) begin
    string_beat_t exp_beat;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_beats.size() == 0) begin
        report_error($sformatf("result %02h with no prediction", out_bus.out_byte));
      end else begin
        exp_beat = pending_beats.pop_front();
        if (out_bus.out_byte !== exp_beat.out_byte)
          report_error($sformatf("out_byte %02h, want %02h",
                                 out_bus.out_byte, exp_beat.out_byte));
        if (out_bus.end_of_string !== exp_beat.end_of_string)
          report_error($sformatf("end_of_string %b, want %b",
                                 out_bus.end_of_string, exp_beat.end_of_string));
        if (out_bus.was_encrypted !== exp_beat.was_encrypted)
          report_error($sformatf("was_encrypted %b, want %b",
                                 out_bus.was_encrypted, exp_beat.was_encrypted));
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("[splitmix_rotate_string_decrypt] ERROR");
          $finish;
        end
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off to fill the block
  initial begin
    int gap;
    int n;
    n = 0;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = (n == HOLD_AT) ? HOLD_CYCLES : draw_gap(n);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
      n++;
    end
  end

  initial begin
    int          pick;
    int          events;
    logic [63:0] seed;
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.in_byte      <= 8'h00;
    in_bus.string_start <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.key_seed    <= 64'h0;
    model_seed = SEED_RESET;
    model_gen  = SEED_RESET;
    model_enc  = 1'b0;
    model_open = 1'b0;

    rows = '{
      beat_row(8'h55, 1'b0, CHK_SILENT, '0),            // no string open yet
      beat_row(8'hFF, 1'b1, CHK_SILENT, '0),            // encrypted, reset seed
      beat_row(8'h01, 1'b0, CHK_MODEL,  '0),
      beat_row(8'hFF, 1'b0, CHK_MODEL,  '0),
      beat_row(8'h80, 1'b0, CHK_MODEL,  '0),
      beat_row(8'h00, 1'b0, CHK_GIVEN,  {8'h00, 1'b1, 1'b1}),
      beat_row(8'h33, 1'b0, CHK_SILENT, '0),            // after end, dropped
      beat_row(8'h00, 1'b1, CHK_SILENT, '0),            // pass-through marker
      beat_row(8'hFF, 1'b0, CHK_GIVEN,  {8'hFF, 1'b0, 1'b0}),
      beat_row(8'h01, 1'b0, CHK_GIVEN,  {8'h01, 1'b0, 1'b0}),
      beat_row(8'h00, 1'b0, CHK_GIVEN,  {8'h00, 1'b1, 1'b0}),
      beat_row(8'h00, 1'b1, CHK_SILENT, '0),            // empty plain string
      beat_row(8'h00, 1'b0, CHK_GIVEN,  {8'h00, 1'b1, 1'b0}),
      seed_row(64'h0),
      beat_row(8'h01, 1'b1, CHK_SILENT, '0),
      beat_row(8'hA5, 1'b0, CHK_MODEL,  '0),
      beat_row(8'h5A, 1'b1, CHK_SILENT, '0),            // restart while open
      beat_row(8'hC3, 1'b0, CHK_MODEL,  '0),
      seed_row(64'hFFFF_FFFF_FFFF_FFFF),                // mid-string, next start only
      beat_row(8'h7E, 1'b0, CHK_MODEL,  '0),
      beat_row(8'h00, 1'b0, CHK_GIVEN,  {8'h00, 1'b1, 1'b1}),
      beat_row(8'h80, 1'b1, CHK_SILENT, '0),
      beat_row(8'h01, 1'b0, CHK_MODEL,  '0),
      beat_row(8'h00, 1'b0, CHK_GIVEN,  {8'h00, 1'b1, 1'b1}),
      beat_row(8'h3C, 1'b0, CHK_SILENT, '0)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (rows[i].kind == ROW_SEED) load_seed(rows[i].seed);
      else offer_byte(rows[i].data, rows[i].start, rows[i].chk, rows[i].want);
    end

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: seed = 64'h0;
        1: seed = 64'hFFFF_FFFF_FFFF_FFFF;
        2: seed = SEED_RESET;
        default: seed = {$urandom, $urandom};
      endcase
      load_seed(seed);
      // Finish a string left open across the seed write
      if (model_open) send_string_bytes($urandom_range(0, 8), 1'b1);
      events = $urandom_range(3, 10);
      repeat (events) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_string(1'b1);
        end else if (pick == 7) begin
          repeat ($urandom_range(1, 3)) offer_byte(8'($urandom_range(0, 255)), 1'b0,
                                                   CHK_MODEL, '0);
        end else begin
          send_string(1'b0);
        end
      end
      if ($urandom_range(0, 1) == 1) send_string(1'b0);
    end

    in_bus.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[splitmix_rotate_string_decrypt] OK");
    end else begin
      $display("[splitmix_rotate_string_decrypt] ERROR");
    end
    $finish;
  end

endmodule

### splitmix_rotate_string_decrypt.f
sv/smrsd_pkg.sv
sv/smrsd_ifs.sv
sv/smrsd_mul32.sv
sv/splitmix_rotate_string_decrypt.sv
sim/splitmix_rotate_string_decrypt_tb.sv
